// File: hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared definitions for the cardiac cell Euler stepper
// Fixed-point format, model constants, sequencer codes and saturation helper.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_STEPS = 1024;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  localparam longint FX_ONE_L  = longint'(1) <<< FRAC_BITS;
  localparam longint K_TIN_L   = ((longint'(10) <<< FRAC_BITS) + 1) / 3;
  localparam longint K_TOUT_L  = (FX_ONE_L + 3) / 6;
  localparam longint K_OPEN_L  = (FX_ONE_L + 60) / 120;
  localparam longint K_CLOSE_L = (FX_ONE_L + 75) / 150;
  localparam longint K_VGATE_L = ((longint'(13) <<< FRAC_BITS) + 50) / 100;

  localparam logic signed [31:0] FX_ONE  = 32'(FX_ONE_L);
  localparam logic signed [31:0] K_TIN   = 32'(K_TIN_L);
  localparam logic signed [31:0] K_TOUT  = 32'(K_TOUT_L);
  localparam logic signed [31:0] K_OPEN  = 32'(K_OPEN_L);
  localparam logic signed [31:0] K_CLOSE = 32'(K_CLOSE_L);
  localparam logic signed [31:0] K_VGATE = 32'(K_VGATE_L);

  localparam logic [30:0] DT_RESET = 31'd2684355;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // One phase per cycle of an Euler step.
  typedef enum logic [9:0] {
    PH_VV   = 10'b0000000001,
    PH_JOUT = 10'b0000000010,
    PH_CUBE = 10'b0000000100,
    PH_GATE = 10'b0000001000,
    PH_HT   = 10'b0000010000,
    PH_DTH  = 10'b0000100000,
    PH_JIN  = 10'b0001000000,
    PH_DV   = 10'b0010000000,
    PH_DTV  = 10'b0100000000,
    PH_UPD  = 10'b1000000000
  } phase_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh07FFFFFFF;
    lo = -36'sh080000000;
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// File: hdl/cardiac_cell_euler_step.sv
// ----------------------------------------------------------------------------
// cardiac_cell_euler_step: Mitchell-Schaeffer cell, forward Euler integrator
// Applies step_count Euler steps to one cell in signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | voltage_in, gate_in, stimulus, step_count
//  result   | out_valid / out_ready| voltage_out, gate_out
//  config   | cfg_wr_en            | cfg_wr_data (time step dt)
//
// Each Euler step runs through phases PH_VV to PH_UPD: the eight products of
// a step go through one shared 32x32 multiplier, and a dependent product waits
// for the registered product to be rounded. A transaction runs its step count
// (clamped to MAX_STEPS) of steps; a zero count goes straight to the output.
// Synchronous active-low reset clears the sequencer and loads the default dt.
// The input is not ready while a cell is in progress; a finished result waits
// in its own output register, so a stalled output side only holds the final
// hand-off and the next input transaction can be taken meanwhile.
// ----------------------------------------------------------------------------
module cardiac_cell_euler_step
  import ccs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_voltage_in,
  input  logic signed [31:0] in_gate_in,
  input  logic signed [31:0] in_stimulus,
  input  logic [10:0]        in_step_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_voltage_out,
  output logic signed [31:0] out_gate_out
);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  remaining_r, remaining_nxt;
  logic [30:0]       dt_r, dt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working values of the cell; these carry no reset.
  logic signed [31:0] v_r, h_r, stim_r;
  logic signed [31:0] omv_r, omh_r;
  logic               gate_open_r;
  logic signed [31:0] t_r, jout_r, dh_r, hnew_r, dv_r;
  logic signed [31:0] vout_r, hout_r;

  logic signed [31:0] op_a, op_b, rnd;
  logic signed [31:0] dt_s;
  logic               in_fire, load_out, last_step;
  logic [CNT_W-1:0]   count_clamped;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign dt_s      = {1'b0, dt_r};
  assign last_step = (remaining_r == CNT_W'(1));
  assign load_out  = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  assign count_clamped = (in_step_count > 11'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                          : CNT_W'(in_step_count);

  // The shared multiplier. Its rounded output in any phase belongs to the
  // product issued in the previous phase.
  ccs_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .rnd  (rnd)
  );

  // Operand selection for the product issued in each phase.
  always_comb begin
    op_a = v_r;
    op_b = v_r;
    case (phase_r)
      PH_VV: begin
        op_a = v_r;
        op_b = v_r;
      end
      PH_JOUT: begin
        op_a = v_r;
        op_b = K_TOUT;
      end
      PH_CUBE: begin
        op_a = t_r;
        op_b = omv_r;
      end
      PH_GATE: begin
        op_a = gate_open_r ? omh_r  : h_r;
        op_b = gate_open_r ? K_OPEN : K_CLOSE;
      end
      PH_HT: begin
        op_a = h_r;
        op_b = t_r;
      end
      PH_DTH: begin
        op_a = dt_s;
        op_b = dh_r;
      end
      PH_JIN: begin
        op_a = t_r;
        op_b = K_TIN;
      end
      PH_DTV: begin
        op_a = dt_s;
        op_b = dv_r;
      end
      default: begin
        op_a = v_r;
        op_b = v_r;
      end
    endcase
  end

  // Sequencer and output-register control.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    dt_nxt        = cfg_wr_en ? cfg_wr_data : dt_r;
    out_valid_nxt = (out_valid_r && !out_ready) || load_out;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          remaining_nxt = count_clamped;
          phase_nxt     = PH_VV;
          state_nxt     = (count_clamped == '0) ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        case (phase_r)
          PH_VV:   phase_nxt = PH_JOUT;
          PH_JOUT: phase_nxt = PH_CUBE;
          PH_CUBE: phase_nxt = PH_GATE;
          PH_GATE: phase_nxt = PH_HT;
          PH_HT:   phase_nxt = PH_DTH;
          PH_DTH:  phase_nxt = PH_JIN;
          PH_JIN:  phase_nxt = PH_DV;
          PH_DV:   phase_nxt = PH_DTV;
          PH_DTV:  phase_nxt = PH_UPD;
          PH_UPD: begin
            phase_nxt     = PH_VV;
            remaining_nxt = remaining_r - CNT_W'(1);
            if (last_step) begin
              state_nxt = ST_HOLD;
            end
          end
          default: phase_nxt = PH_VV;
        endcase
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_VV;
      remaining_r <= '0;
      dt_r        <= DT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      dt_r        <= dt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath write-back. Both derivatives of a step use the old v and h;
  // the new h waits in hnew_r until v is updated in the last phase.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r    <= in_voltage_in;
      h_r    <= in_gate_in;
      stim_r <= in_stimulus;
    end
    if (state_r == ST_RUN) begin
      case (phase_r)
        PH_VV: begin
          omv_r       <= sat32(36'(FX_ONE) - 36'(v_r));
          omh_r       <= sat32(36'(FX_ONE) - 36'(h_r));
          gate_open_r <= (v_r < K_VGATE);
        end
        PH_JOUT: t_r    <= rnd;
        PH_CUBE: jout_r <= rnd;
        PH_GATE: t_r    <= rnd;
        PH_HT: begin
          // Opening gate keeps the product; closing gate is its negation.
          dh_r <= gate_open_r ? rnd : sat32(-36'(rnd));
        end
        PH_DTH:  t_r    <= rnd;
        PH_JIN:  hnew_r <= sat32(36'(h_r) + 36'(rnd));
        PH_DV:   dv_r   <= sat32(36'(stim_r) + 36'(rnd) - 36'(jout_r));
        PH_UPD: begin
          v_r <= sat32(36'(v_r) + 36'(rnd));
          h_r <= hnew_r;
        end
        default: begin
        end
      endcase
    end
    if (load_out) begin
      vout_r <= v_r;
      hout_r <= h_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voltage_out = vout_r;
  assign out_gate_out    = hout_r;

  // The step phase is always a single phase while a cell is in progress.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> $onehot(phase_r))
    else $error("phase register is not one-hot during a step");

  // A running cell always has at least one step left.
  a_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (remaining_r != '0))
    else $error("running with no steps left");

  // A transaction with steps starts the first step right away.
  a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_step_count != 11'd0)) |=> (state_r == ST_RUN) && (phase_r == PH_VV))
    else $error("accepted transaction did not start stepping");

  // The update phase of the last step hands over to the output stage.
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && (phase_r == PH_UPD) && last_step) |=> (state_r == ST_HOLD))
    else $error("last step did not finish the transaction");

endmodule

// File: hdl/ccs_mul.sv
// ----------------------------------------------------------------------------
// ccs_mul: shared fixed-point multiplier
// Registers the full 64-bit product, then rounds half up and saturates it.
// ----------------------------------------------------------------------------
module ccs_mul
  import ccs_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [31:0] rnd
);

  logic signed [63:0] prod_r;
  logic signed [63:0] biased;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Arithmetic shift of the biased product is the floor of the quotient.
  assign biased = prod_r + (64'sd1 <<< (FRAC_BITS - 1));
  assign rnd    = sat32(36'(biased >>> FRAC_BITS));

endmodule
